FILE: rtl/assert_macros.svh
// assertion macros used by set_assoc_cache_lru_unit
// needs clk and rst in scope where used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked check, off during reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/sacl_pkg.sv
// shared types and constants for the set-associative cache
// no dependencies
package sacl_pkg;

  localparam int WORD_W    = 32;
  localparam int AGE_W     = 8;
  localparam int WAY_IDX_W = 4;

  localparam logic [AGE_W-1:0]  AGE_MAX = 8'hFF;
  localparam logic [WORD_W-1:0] CNT_MAX = 32'hFFFF_FFFF;

  typedef enum logic {
    FUNC_READ  = 1'b0,
    FUNC_WRITE = 1'b1
  } func_t;

  typedef struct packed {
    logic                 hit;
    logic [WAY_IDX_W-1:0] way;
  } lookup_t;

endpackage

FILE: rtl/sacl_lookup.sv
// tag compare, victim choice and age update for one set
// depends on sacl_pkg
module sacl_lookup #(
  parameter int WAYS  = 4,
  parameter int TAG_W = 21
) (
  input  logic [TAG_W-1:0]                 tag,
  input  logic [WAYS-1:0]                  valid_row,
  input  logic [WAYS*TAG_W-1:0]            tag_row,
  input  logic [WAYS*sacl_pkg::AGE_W-1:0]  age_row,
  output logic [WAYS-1:0]                  match,
  output sacl_pkg::lookup_t                lk,
  output logic [WAYS*sacl_pkg::AGE_W-1:0]  age_row_next
);

  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AGE_W = sacl_pkg::AGE_W;

  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] victim;
  logic [WAY_W-1:0] way;
  logic [AGE_W-1:0] best_age;
  logic [AGE_W-1:0] age_w;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w] = valid_row[w] && (tag_row[w*TAG_W +: TAG_W] == tag);
    end
  end

  // lowest matching way wins
  always_comb begin
    hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAY_W'(w);
      end
    end
  end

  // first valid way with the greatest nonzero age, else way 0
  always_comb begin
    victim   = '0;
    best_age = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (valid_row[w] && (age_row[w*AGE_W +: AGE_W] > best_age)) begin
        best_age = age_row[w*AGE_W +: AGE_W];
        victim   = WAY_W'(w);
      end
    end
  end

  always_comb begin
    way    = (|match) ? hit_way : victim;
    lk     = '0;
    lk.hit = |match;
    lk.way[WAY_W-1:0] = way;
  end

  always_comb begin
    age_row_next = age_row;
    for (int w = 0; w < WAYS; w++) begin
      age_w = age_row[w*AGE_W +: AGE_W];
      if (WAY_W'(w) == way) begin
        age_row_next[w*AGE_W +: AGE_W] = '0;
      end else if (valid_row[w] && (age_w != sacl_pkg::AGE_MAX)) begin
        age_row_next[w*AGE_W +: AGE_W] = age_w + AGE_W'(1);
      end
    end
  end

endmodule

FILE: rtl/set_assoc_cache_lru_unit.sv
// set-associative word cache, age-based lru, write allocate, no line fill
// depends on sacl_pkg, sacl_lookup and assert_macros.svh
//
//   channel  direction  handshake           payload
//   in       into       in_valid/in_ready    func, addr, write_data
//   out      out of     out_valid/out_ready  hit, read_data, four counters
//
// one transaction per cycle sustained while the result is taken and the clear is done; an accepted
// input is registered in stage one (rows read), then lookup and write back register the result
// after reset a clearing pass zeroes all NUM_SETS*LINE_BYTES/4 rows of the data memory
// (512 by default), while in_ready stays low
// a stalled result holds; the next transaction still enters while one waits
// back-to-back accesses to the same set are forwarded past the memories
`include "assert_macros.svh"

module set_assoc_cache_lru_unit #(
  parameter int NUM_SETS   = 64,
  parameter int WAYS       = 4,
  parameter int LINE_BYTES = 32,
  parameter int ADDR_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [31:0] addr,
  input  logic [31:0] write_data,

  output logic        out_valid,
  input  logic        out_ready,
  output logic        hit,
  output logic [31:0] read_data,
  output logic [31:0] read_hit_count,
  output logic [31:0] read_miss_count,
  output logic [31:0] write_hit_count,
  output logic [31:0] write_miss_count
);

  localparam int WORD_W    = sacl_pkg::WORD_W;
  localparam int AGE_W     = sacl_pkg::AGE_W;
  localparam int OFF_BITS  = $clog2(LINE_BYTES);
  localparam int IDX_BITS  = $clog2(NUM_SETS);
  localparam int WPL       = LINE_BYTES / 4;
  localparam int WORD_BITS = $clog2(WPL);
  localparam int SET_W     = (NUM_SETS > 1) ? IDX_BITS : 1;
  localparam int WSEL_W    = (WPL > 1) ? WORD_BITS : 1;
  localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_SHIFT = OFF_BITS + IDX_BITS;
  localparam int TAG_BITS  = ADDR_WIDTH - TAG_SHIFT;
  localparam int TAG_W     = (TAG_BITS > 0) ? TAG_BITS : 1;
  localparam int ROWS      = NUM_SETS * WPL;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;

  localparam logic [32:0] ADDR_SPAN = 33'd1 << ADDR_WIDTH;
  localparam logic [31:0] ADDR_MASK = 32'(ADDR_SPAN - 33'd1);

  // address decode at the input
  logic [31:0]       addr_m;
  logic [31:0]       sh_set;
  logic [31:0]       sh_word;
  logic [31:0]       sh_tag;
  logic [SET_W-1:0]  in_set;
  logic [WSEL_W-1:0] in_word;
  logic [TAG_W-1:0]  in_tag;
  logic [ROW_W-1:0]  in_row;

  always_comb begin
    addr_m  = addr & ADDR_MASK;
    sh_set  = addr_m >> OFF_BITS;
    sh_word = addr_m >> 2;
    sh_tag  = (TAG_SHIFT >= 32) ? 32'd0 : (addr_m >> TAG_SHIFT);
    in_set  = (NUM_SETS > 1) ? sh_set[SET_W-1:0] : '0;
    in_word = (WPL > 1) ? sh_word[WSEL_W-1:0] : '0;
    in_tag  = sh_tag[TAG_W-1:0];
    in_row  = ROW_W'((32'(in_set) << WORD_BITS) | 32'(in_word));
  end

  // handshake
  logic in_fire;
  logic s1_valid;
  logic s1_fire;
  logic clear_done;
  logic [ROW_W-1:0] clr_idx;

  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = clear_done && (!s1_valid || s1_fire);
  assign in_fire  = in_valid && in_ready;

  // storage
  logic [WAYS*TAG_W-1:0]  tag_mem  [NUM_SETS];
  logic [WAYS*AGE_W-1:0]  age_mem  [NUM_SETS];
  logic [WAYS*WORD_W-1:0] data_mem [ROWS];
  logic [WAYS-1:0]        line_valid [NUM_SETS];

  // stage one registers
  sacl_pkg::func_t        s1_func;
  logic [WORD_W-1:0]      s1_wdata;
  logic [SET_W-1:0]       s1_set;
  logic [ROW_W-1:0]       s1_row;
  logic [TAG_W-1:0]       s1_tag;
  logic [WAYS*TAG_W-1:0]  tag_rd;
  logic [WAYS*AGE_W-1:0]  age_rd;
  logic [WAYS*WORD_W-1:0] data_rd;
  logic                   byp_set;
  logic                   byp_data;
  logic [WAYS*TAG_W-1:0]  byp_tag_row;
  logic [WAYS*AGE_W-1:0]  byp_age_row;
  logic [WAYS*WORD_W-1:0] byp_data_row;

  // lookup and write back
  logic [WAYS*TAG_W-1:0]  tag_row;
  logic [WAYS*AGE_W-1:0]  age_row;
  logic [WAYS*WORD_W-1:0] data_row;
  logic [WAYS-1:0]        valid_row;
  logic [WAYS-1:0]        match;
  sacl_pkg::lookup_t      lk;
  logic [WAY_W-1:0]       way;
  logic [WAYS*AGE_W-1:0]  age_row_next;
  logic [WAYS*TAG_W-1:0]  tag_row_next;
  logic [WAYS*WORD_W-1:0] data_row_next;
  logic [WORD_W-1:0]      rdata;
  logic                   s1_write;

  assign tag_row   = byp_set ? byp_tag_row : tag_rd;
  assign age_row   = byp_set ? byp_age_row : age_rd;
  assign data_row  = byp_data ? byp_data_row : data_rd;
  assign valid_row = line_valid[s1_set];
  assign s1_write  = (s1_func == sacl_pkg::FUNC_WRITE);
  assign way       = lk.way[WAY_W-1:0];

  sacl_lookup #(
    .WAYS  (WAYS),
    .TAG_W (TAG_W)
  ) u_lookup (
    .tag          (s1_tag),
    .valid_row    (valid_row),
    .tag_row      (tag_row),
    .age_row      (age_row),
    .match        (match),
    .lk           (lk),
    .age_row_next (age_row_next)
  );

  always_comb begin
    tag_row_next  = tag_row;
    data_row_next = data_row;
    rdata         = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (WAY_W'(w) == way) begin
        tag_row_next[w*TAG_W +: TAG_W]   = s1_tag;
        data_row_next[w*WORD_W +: WORD_W] = s1_wdata;
        if (lk.hit && !s1_write) begin
          rdata = data_row[w*WORD_W +: WORD_W];
        end
      end
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      tag_mem[s1_set] <= tag_row_next;
      age_mem[s1_set] <= age_row_next;
    end
    if (in_fire) begin
      tag_rd <= tag_mem[in_set];
      age_rd <= age_mem[in_set];
    end
  end

  always_ff @(posedge clk) begin
    if (!clear_done) begin
      data_mem[clr_idx] <= '0;
    end else if (s1_fire && s1_write) begin
      data_mem[s1_row] <= data_row_next;
    end
    if (in_fire) begin
      data_rd <= data_mem[in_row];
    end
  end

  // stage one payload and forwarding
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func      <= sacl_pkg::func_t'(func);
      s1_wdata     <= write_data;
      s1_set       <= in_set;
      s1_row       <= in_row;
      s1_tag       <= in_tag;
      byp_set      <= s1_fire && (s1_set == in_set);
      byp_data     <= s1_fire && s1_write && (s1_row == in_row);
      byp_tag_row  <= tag_row_next;
      byp_age_row  <= age_row_next;
      byp_data_row <= data_row_next;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      hit       <= lk.hit;
      read_data <= rdata;
    end
  end

  // control, valid bits and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid         <= 1'b0;
      out_valid        <= 1'b0;
      clear_done       <= 1'b0;
      clr_idx          <= '0;
      read_hit_count   <= '0;
      read_miss_count  <= '0;
      write_hit_count  <= '0;
      write_miss_count <= '0;
      for (int s = 0; s < NUM_SETS; s++) begin
        line_valid[s] <= '0;
      end
    end else begin
      if (!clear_done) begin
        if (clr_idx == ROW_W'(ROWS - 1)) begin
          clear_done <= 1'b1;
        end else begin
          clr_idx <= clr_idx + ROW_W'(1);
        end
      end

      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end

      if (s1_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (s1_fire) begin
        line_valid[s1_set][way] <= 1'b1;
        if (s1_write) begin
          if (lk.hit) begin
            if (write_hit_count != sacl_pkg::CNT_MAX) begin
              write_hit_count <= write_hit_count + 32'd1;
            end
          end else if (write_miss_count != sacl_pkg::CNT_MAX) begin
            write_miss_count <= write_miss_count + 32'd1;
          end
        end else begin
          if (lk.hit) begin
            if (read_hit_count != sacl_pkg::CNT_MAX) begin
              read_hit_count <= read_hit_count + 32'd1;
            end
          end else if (read_miss_count != sacl_pkg::CNT_MAX) begin
            read_miss_count <= read_miss_count + 32'd1;
          end
        end
      end
    end
  end

  // checks
  `ASSERT_IMPL(a_single_match, s1_valid, $countones(match) <= 1, "two valid ways hold one tag")
  `ASSERT_IMPL(a_quiet_in_clear, !clear_done, !s1_valid && !out_valid, "transaction during clear")
  `ASSERT_NEXT(a_way_installed, s1_fire && !rst, line_valid[$past(s1_set)][$past(way)], "used way not valid")
  `ASSERT_NEXT(a_one_counter, s1_fire && !rst, (3'(read_hit_count != $past(read_hit_count)) + 3'(read_miss_count != $past(read_miss_count)) + 3'(write_hit_count != $past(write_hit_count)) + 3'(write_miss_count != $past(write_miss_count))) <= 3'd1, "more than one counter moved")
  `ASSERT_NEXT(a_counters_hold, !s1_fire && !rst, $stable(read_hit_count) && $stable(read_miss_count) && $stable(write_hit_count) && $stable(write_miss_count), "counter moved without access")

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for set_assoc_cache_lru_unit: directed and random word accesses
// predicts every transaction with its own cache state; depends on sacl_pkg and the rtl top
module tb_top;

  localparam int SETS        = 64;
  localparam int WAYS        = 4;
  localparam int WORDS       = 8;
  localparam int LINES       = SETS * WAYS;
  localparam int IDLE_LIMIT  = 4000;
  localparam int RAND_ITEMS  = 700;

  typedef struct {
    sacl_pkg::func_t kind;
    logic [31:0]     byte_addr;
    logic [31:0]     wdata;
  } access_t;

  typedef struct {
    logic        hit;
    logic [31:0] read_data;
    logic [31:0] rd_hits;
    logic [31:0] rd_misses;
    logic [31:0] wr_hits;
    logic [31:0] wr_misses;
  } access_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        func = sacl_pkg::FUNC_READ;
  logic [31:0] addr = '0;
  logic [31:0] write_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        hit;
  logic [31:0] read_data;
  logic [31:0] read_hit_count;
  logic [31:0] read_miss_count;
  logic [31:0] write_hit_count;
  logic [31:0] write_miss_count;

  access_t        access_queue[$];
  access_result_t pending_results[$];

  logic        way_valid [LINES];
  logic [20:0] way_tag   [LINES];
  logic [7:0]  way_age   [LINES];
  logic [31:0] data_mem  [LINES*WORDS];
  logic [31:0] cnt_rd_hit, cnt_rd_miss, cnt_wr_hit, cnt_wr_miss;

  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          idle_cycles = 0;
  int          in_wait = 0;
  int          out_wait = 0;
  int          gap;
  access_t     nxt;
  access_result_t exp_res;

  set_assoc_cache_lru_unit u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .func             (func),
    .addr             (addr),
    .write_data       (write_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .hit              (hit),
    .read_data        (read_data),
    .read_hit_count   (read_hit_count),
    .read_miss_count  (read_miss_count),
    .write_hit_count  (write_hit_count),
    .write_miss_count (write_miss_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] sat_inc(logic [31:0] c);
    return (c == sacl_pkg::CNT_MAX) ? c : c + 32'd1;
  endfunction

  function automatic access_result_t predict_access(sacl_pkg::func_t kind, logic [31:0] a,
                                                    logic [31:0] d);
    logic [20:0]    tg;
    int             base;
    int             way;
    int             best_age;
    logic           found;
    access_result_t r;
    tg       = a[31:11];
    base     = a[10:5] * WAYS;
    way      = 0;
    found    = 1'b0;
    best_age = 0;
    for (int w = 0; w < WAYS; w++) begin
      if (!found && way_valid[base+w] && way_tag[base+w] == tg) begin
        found = 1'b1;
        way   = w;
      end
    end
    if (!found) begin
      for (int w = 0; w < WAYS; w++) begin
        if (way_valid[base+w] && way_age[base+w] > best_age) begin
          best_age = way_age[base+w];
          way      = w;
        end
      end
      way_tag[base+way]   = tg;
      way_valid[base+way] = 1'b1;
    end
    r.read_data = '0;
    if (kind == sacl_pkg::FUNC_WRITE)
      data_mem[(base+way)*WORDS + a[4:2]] = d;
    else if (found)
      r.read_data = data_mem[(base+way)*WORDS + a[4:2]];
    way_age[base+way] = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (w != way && way_valid[base+w] && way_age[base+w] != sacl_pkg::AGE_MAX)
        way_age[base+w] = way_age[base+w] + 8'd1;
    end
    if (kind == sacl_pkg::FUNC_WRITE) begin
      if (found) cnt_wr_hit = sat_inc(cnt_wr_hit);
      else cnt_wr_miss = sat_inc(cnt_wr_miss);
    end else begin
      if (found) cnt_rd_hit = sat_inc(cnt_rd_hit);
      else cnt_rd_miss = sat_inc(cnt_rd_miss);
    end
    r.hit       = found;
    r.rd_hits   = cnt_rd_hit;
    r.rd_misses = cnt_rd_miss;
    r.wr_hits   = cnt_wr_hit;
    r.wr_misses = cnt_wr_miss;
    return r;
  endfunction

  // calm stretches with no idling on either side
  function automatic int draw_wait();
    return (cycle_count[8:7] == 2'd0) ? 0 : $urandom_range(0, 14);
  endfunction

  task automatic check_field(string name, logic [31:0] expv, logic [31:0] act);
    if (expv !== act) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h actual %h", $realtime, name, expv, act);
    end
  endtask

  task automatic add_access(sacl_pkg::func_t kind, logic [31:0] a, logic [31:0] d);
    access_t t;
    t.kind      = kind;
    t.byte_addr = a;
    t.wdata     = d;
    access_queue.push_back(t);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_wait  <= draw_wait();
    end else if (in_valid && in_ready) begin
      pending_results.push_back(predict_access(sacl_pkg::func_t'(func), addr, write_data));
      gap = draw_wait();
      if (gap == 0 && access_queue.size() != 0) begin
        nxt = access_queue.pop_front();
        func       <= nxt.kind;
        addr       <= nxt.byte_addr;
        write_data <= nxt.wdata;
      end else begin
        in_valid <= 1'b0;
        in_wait  <= gap;
      end
    end else if (!in_valid) begin
      if (in_wait > 0) begin
        in_wait <= in_wait - 1;
      end else if (access_queue.size() != 0) begin
        nxt = access_queue.pop_front();
        func       <= nxt.kind;
        addr       <= nxt.byte_addr;
        write_data <= nxt.wdata;
        in_valid   <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_wait  <= 0;
    end else if (out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none actual hit=%b read_data=%h",
                 $realtime, hit, read_data);
      end else begin
        exp_res = pending_results.pop_front();
        check_field("hit", {31'd0, exp_res.hit}, {31'd0, hit});
        check_field("read_data", exp_res.read_data, read_data);
        check_field("read_hit_count", exp_res.rd_hits, read_hit_count);
        check_field("read_miss_count", exp_res.rd_misses, read_miss_count);
        check_field("write_hit_count", exp_res.wr_hits, write_hit_count);
        check_field("write_miss_count", exp_res.wr_misses, write_miss_count);
      end
      gap = draw_wait();
      if (gap != 0) begin
        out_ready <= 1'b0;
        out_wait  <= gap;
      end
    end else if (!out_ready) begin
      if (out_wait > 0) out_wait <= out_wait - 1;
      else out_ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [5:0]  hot_set [6];
    logic [20:0] hot_tag [6][3];
    logic [31:0] a;
    int          s;
    for (int i = 0; i < LINES; i++) begin
      way_valid[i] = 1'b0;
      way_tag[i]   = '0;
      way_age[i]   = '0;
    end
    for (int i = 0; i < LINES*WORDS; i++) data_mem[i] = '0;
    cnt_rd_hit  = '0;
    cnt_rd_miss = '0;
    cnt_wr_hit  = '0;
    cnt_wr_miss = '0;

    // directed: extremes, hit/miss of each kind, stale words after replacement
    add_access(sacl_pkg::FUNC_READ,  32'h0000_0000, 32'h0000_0000);
    add_access(sacl_pkg::FUNC_WRITE, 32'h0000_0000, 32'hFFFF_FFFF);
    add_access(sacl_pkg::FUNC_READ,  32'h0000_0000, 32'h1234_5678);
    add_access(sacl_pkg::FUNC_READ,  32'h0000_001C, 32'hFFFF_FFFF);
    add_access(sacl_pkg::FUNC_WRITE, 32'hFFFF_FFE0, 32'h0000_FFFF);
    add_access(sacl_pkg::FUNC_WRITE, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
    add_access(sacl_pkg::FUNC_READ,  32'hFFFF_FFFD, 32'h0000_0000);
    add_access(sacl_pkg::FUNC_WRITE, 32'h7FFF_FFFC, 32'h5A5A_5A5A);
    add_access(sacl_pkg::FUNC_READ,  32'h7FFF_FFE0, 32'h0000_0000);
    add_access(sacl_pkg::FUNC_READ,  32'hFFFF_FFFC, 32'h0000_0000);
    add_access(sacl_pkg::FUNC_WRITE, 32'h1234_5678, 32'hDEAD_BEEF);
    add_access(sacl_pkg::FUNC_WRITE, 32'h1234_567B, 32'h0000_0000);
    add_access(sacl_pkg::FUNC_READ,  32'h1234_5679, 32'h0000_0000);
    add_access(sacl_pkg::FUNC_READ,  32'h8000_0000, 32'h0000_0000);
    add_access(sacl_pkg::FUNC_WRITE, 32'h0000_0800, 32'h8000_0001);
    add_access(sacl_pkg::FUNC_READ,  32'h0000_0000, 32'h0000_0000);
    add_access(sacl_pkg::FUNC_READ,  32'h0000_0800, 32'h0000_0000);
    add_access(sacl_pkg::FUNC_WRITE, 32'h0000_0804, 32'h7FFF_FFFE);

    // random: a few hot sets with small tag pools so hits and evictions are common
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 100 == 0) begin
        for (int k = 0; k < 6; k++) begin
          hot_set[k] = 6'($urandom);
          for (int j = 0; j < 3; j++) hot_tag[k][j] = 21'($urandom);
        end
      end
      if ($urandom_range(0, 9) < 8) begin
        s = $urandom_range(0, 5);
        a = {hot_tag[s][$urandom_range(0, 2)], hot_set[s], 5'($urandom)};
      end else begin
        a = $urandom;
      end
      add_access(sacl_pkg::func_t'($urandom_range(0, 1)), a, $urandom);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (access_queue.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
